>>> src/pcs_pkg.sv
// Shared types and constants for the per-channel contrast stretch block.
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned COUNT_W   = 2;
  // One quotient bit per step; the quotient never exceeds eight bits.
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0]  CHAN_COUNT_RESET = 2'd3;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX       = 8'd255;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN       = 8'd0;

  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_MAP     = 1'b1;

  typedef struct packed {
    logic                func;
    logic                frame_start;
    logic [SAMPLE_W-1:0] chan0;
    logic [SAMPLE_W-1:0] chan1;
    logic [SAMPLE_W-1:0] chan2;
  } pixel_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out0;
    logic [SAMPLE_W-1:0] out1;
    logic [SAMPLE_W-1:0] out2;
    logic                flat_range;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic meas;     // update running min/max with the accepted pixel
    logic capture;  // hold the samples of an accepted map pixel
    logic prep;     // form dividend, divisor and lane selection
    logic step;     // one restoring division step in every lane
    logic emit;     // load the result register
  } pcs_cmd_t;

endpackage

`default_nettype wire

>>> src/per_channel_contrast_stretch.sv
// Top level of the per-channel min-max contrast stretch block.
//
// Usage: pixels arrive on the pixel request channel (pixel_valid/pixel_ready,
// payload pixel). A measure pixel (func low) updates the running minimum and
// maximum of each active channel; frame_start first resets them to 255 and 0.
// A measure pixel is taken and gives no result.
// A map pixel (func high) gives one result on the result channel
// (result_valid/result_ready, payload result): each active channel rounded
// (x-min)*255/(max-min), saturated, or zero with flat_range raised when the
// channel's range is empty. An inactive channel passes its sample through.
// A map pixel passes through accept, operand setup, eight restoring
// division steps (one quotient bit per step, all three channels in parallel)
// and a load of the output register.
// The output register parts the two sides: while a result waits, measure
// pixels are still taken, and a map pixel runs up to its final load and waits
// there until the receiver takes the older result.
// The channel count is written on cfg_valid/cfg_data, always ready; the user
// must write it only while the block is idle; the block does not enforce it.
// Synchronous reset sets the count to three, every minimum to 255, every
// maximum to 0, and drops result_valid.
`timescale 1ns / 1ps
`default_nettype none

module per_channel_contrast_stretch (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pcs_pkg::COUNT_W-1:0]   cfg_data,
  input  wire logic                          pixel_valid,
  output logic                               pixel_ready,
  input  wire pcs_pkg::pixel_t               pixel,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output pcs_pkg::result_t                   result
);

  pcs_pkg::pcs_cmd_t cmd;

  // The configuration register can always be written.
  assign cfg_ready = 1'b1;

  pcs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .func         (pixel.func),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  pcs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .pixel     (pixel),
    .cmd       (cmd),
    .result    (result)
  );

endmodule

`default_nettype wire

>>> src/pcs_ctrl.sv
// Controller state machine for the contrast stretch block.
`timescale 1ns / 1ps
`default_nettype none

module pcs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pixel_valid,
  output logic                 pixel_ready,
  input  wire logic            func,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output pcs_pkg::pcs_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                       state;
  logic [pcs_pkg::STEP_W-1:0]   step_count;
  logic                         out_free;

  assign pixel_ready = (state == ST_IDLE);
  assign out_free    = !result_valid || result_ready;

  always_comb begin
    cmd         = '0;
    cmd.meas    = (state == ST_IDLE) && pixel_valid && (func == pcs_pkg::FUNC_MEASURE);
    cmd.capture = (state == ST_IDLE) && pixel_valid && (func == pcs_pkg::FUNC_MAP);
    cmd.prep    = (state == ST_PREP);
    cmd.step    = (state == ST_DIV);
    cmd.emit    = (state == ST_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      // A new load wins over the retirement of the older result at the same edge.
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.capture) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          step_count <= '0;
          state      <= ST_DIV;
        end
        ST_DIV: begin
          step_count <= step_count + 1'b1;
          if (step_count == pcs_pkg::STEP_W'(pcs_pkg::DIV_STEPS - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/pcs_datapath.sv
// Datapath: channel count, running min/max, three division lanes, result register.
`timescale 1ns / 1ps
`default_nettype none

module pcs_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  input  wire logic [pcs_pkg::COUNT_W-1:0]   cfg_data,
  input  wire pcs_pkg::pixel_t               pixel,
  input  wire pcs_pkg::pcs_cmd_t             cmd,
  output pcs_pkg::result_t                   result
);

  localparam int unsigned W  = pcs_pkg::SAMPLE_W;
  localparam int unsigned NW = 2 * W + 1;  // dividend width
  localparam int unsigned DW = W + 1;      // divisor width

  typedef enum logic [1:0] {
    SEL_PASS,
    SEL_ZERO,
    SEL_FULL,
    SEL_QUOT
  } lane_sel_t;

  logic [pcs_pkg::COUNT_W-1:0] chan_count;
  logic [pcs_pkg::NUM_CH-1:0]  active;
  logic [W-1:0]                x_in   [pcs_pkg::NUM_CH];
  logic [W-1:0]                lane_out [pcs_pkg::NUM_CH];
  logic [pcs_pkg::NUM_CH-1:0]  lane_flat;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count <= pcs_pkg::CHAN_COUNT_RESET;
    end else if (cfg_valid) begin
      chan_count <= cfg_data;
    end
  end

  // A count of zero behaves as one.
  assign active[0] = 1'b1;
  assign active[1] = (chan_count >= 2'd2);
  assign active[2] = (chan_count == 2'd3);

  assign x_in[0] = pixel.chan0;
  assign x_in[1] = pixel.chan1;
  assign x_in[2] = pixel.chan2;

  for (genvar c = 0; c < pcs_pkg::NUM_CH; c++) begin : g_lane
    logic [W-1:0]  lo;
    logic [W-1:0]  hi;
    logic [W-1:0]  base_lo;
    logic [W-1:0]  base_hi;
    logic [W-1:0]  x;
    logic [W-1:0]  rng;
    logic [NW-1:0] num;
    logic [DW-1:0] div;
    logic [DW-1:0] rem;
    logic [W-1:0]  dvd;
    logic [DW:0]   trial;
    logic          fits;
    lane_sel_t     sel;
    logic          flat;

    assign base_lo = pixel.frame_start ? pcs_pkg::SAMPLE_MAX : lo;
    assign base_hi = pixel.frame_start ? pcs_pkg::SAMPLE_MIN : hi;

    always_ff @(posedge clk) begin
      if (rst) begin
        lo <= pcs_pkg::SAMPLE_MAX;
        hi <= pcs_pkg::SAMPLE_MIN;
      end else if (cmd.meas) begin
        lo <= (active[c] && (x_in[c] < base_lo)) ? x_in[c] : base_lo;
        hi <= (active[c] && (x_in[c] > base_hi)) ? x_in[c] : base_hi;
      end
    end

    // Rounded quotient: (2*(x-lo)*255 + rng) / (2*rng).
    assign rng   = hi - lo;
    assign num   = NW'(x - lo) * NW'(2 * 255) + NW'(rng);
    assign trial = {rem, dvd[W-1]};
    assign fits  = (trial >= {1'b0, div});

    always_ff @(posedge clk) begin
      if (cmd.capture) begin
        x <= x_in[c];
      end
      if (cmd.prep) begin
        rem  <= num[NW-1:W];
        dvd  <= num[W-1:0];
        div  <= {rng, 1'b0};
        flat <= active[c] && (hi <= lo);
        if (!active[c]) begin
          sel <= SEL_PASS;
        end else if ((hi <= lo) || (x <= lo)) begin
          sel <= SEL_ZERO;
        end else if (x >= hi) begin
          sel <= SEL_FULL;
        end else begin
          sel <= SEL_QUOT;
        end
      end else if (cmd.step) begin
        rem <= fits ? DW'(trial - {1'b0, div}) : trial[DW-1:0];
        dvd <= {dvd[W-2:0], fits};
      end
    end

    always_comb begin
      case (sel)
        SEL_PASS: lane_out[c] = x;
        SEL_ZERO: lane_out[c] = pcs_pkg::SAMPLE_MIN;
        SEL_FULL: lane_out[c] = pcs_pkg::SAMPLE_MAX;
        SEL_QUOT: lane_out[c] = dvd;
        default:  lane_out[c] = pcs_pkg::SAMPLE_MIN;
      endcase
    end
    assign lane_flat[c] = flat;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.out0       <= lane_out[0];
      result.out1       <= lane_out[1];
      result.out2       <= lane_out[2];
      result.flat_range <= |lane_flat;
    end
  end

endmodule

`default_nettype wire

>>> tb/pcs_result_checker.sv
// Result checker for the contrast stretch block: predicts every map result and compares it.
`timescale 1ns / 1ps

module pcs_result_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [pcs_pkg::COUNT_W-1:0] cfg_data,
  input  wire logic                        pixel_valid,
  input  wire logic                        pixel_ready,
  input  wire pcs_pkg::pixel_t             pixel,
  input  wire logic                        result_valid,
  input  wire logic                        result_ready,
  input  wire pcs_pkg::result_t            result,
  output int                               mismatches,
  output int                               pending
);
  import pcs_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic [SAMPLE_W-1:0] run_min [NUM_CH];
  logic [SAMPLE_W-1:0] run_max [NUM_CH];
  logic [COUNT_W-1:0]  chan_count;
  result_t             stretched_q [$];
  int                  results_seen;

  // Rounded (x - lo) * 255 / (hi - lo), saturated at both ends.
  function automatic logic [SAMPLE_W-1:0] stretch_sample(input logic [SAMPLE_W-1:0] x,
                                                         input logic [SAMPLE_W-1:0] lo,
                                                         input logic [SAMPLE_W-1:0] hi);
    int unsigned span;
    int unsigned num;
    if (x <= lo) return SAMPLE_MIN;
    if (x >= hi) return SAMPLE_MAX;
    span = int'(hi) - int'(lo);
    num  = 2 * (int'(x) - int'(lo)) * int'(SAMPLE_MAX) + span;
    return SAMPLE_W'(num / (2 * span));
  endfunction

  function automatic int active_count();
    return (chan_count == '0) ? 1 : int'(chan_count);
  endfunction

  function automatic result_t stretch_pixel(input pixel_t p);
    logic [SAMPLE_W-1:0] x [NUM_CH];
    logic [SAMPLE_W-1:0] y [NUM_CH];
    result_t             r;
    logic                flat;
    x[0] = p.chan0;
    x[1] = p.chan1;
    x[2] = p.chan2;
    flat = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (c >= active_count()) begin
        y[c] = x[c];
      end else if (run_max[c] <= run_min[c]) begin
        y[c] = SAMPLE_MIN;
        flat = 1'b1;
      end else begin
        y[c] = stretch_sample(x[c], run_min[c], run_max[c]);
      end
    end
    r.out0       = y[0];
    r.out1       = y[1];
    r.out2       = y[2];
    r.flat_range = flat;
    return r;
  endfunction

  task automatic measure_pixel(input pixel_t p);
    logic [SAMPLE_W-1:0] x [NUM_CH];
    x[0] = p.chan0;
    x[1] = p.chan1;
    x[2] = p.chan2;
    if (p.frame_start) begin
      for (int c = 0; c < NUM_CH; c++) begin
        run_min[c] = SAMPLE_MAX;
        run_max[c] = SAMPLE_MIN;
      end
    end
    for (int c = 0; c < active_count(); c++) begin
      if (x[c] < run_min[c]) run_min[c] = x[c];
      if (x[c] > run_max[c]) run_max[c] = x[c];
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      chan_count = CHAN_COUNT_RESET;
      for (int c = 0; c < NUM_CH; c++) begin
        run_min[c] = SAMPLE_MAX;
        run_max[c] = SAMPLE_MIN;
      end
      stretched_q.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) chan_count = cfg_data;

      // The oldest waiting result is retired before a new request is predicted.
      if (result_valid && result_ready) begin
        results_seen++;
        if (stretched_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d arrived with none expected: out0=%0d out1=%0d out2=%0d flat=%0b",
                     results_seen, result.out0, result.out1, result.out2, result.flat_range);
        end else begin
          want = stretched_q.pop_front();
          if (result.out0 !== want.out0 || result.out1 !== want.out1 ||
              result.out2 !== want.out2 || result.flat_range !== want.flat_range) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result %0d: expected %0d %0d %0d flat=%0b, got %0d %0d %0d flat=%0b",
                       results_seen, want.out0, want.out1, want.out2, want.flat_range,
                       result.out0, result.out1, result.out2, result.flat_range);
          end
        end
      end

      if (pixel_valid && pixel_ready) begin
        if (pixel.func == FUNC_MAP) stretched_q.push_back(stretch_pixel(pixel));
        else                        measure_pixel(pixel);
      end
    end
    pending = stretched_q.size();
  end

endmodule

>>> tb/tb_per_channel_contrast_stretch.sv
// Testbench top for the contrast stretch block: stimulus, receiver pacing and verdict.
`timescale 1ns / 1ps

module tb_per_channel_contrast_stretch;
  import pcs_pkg::*;

  // This tail lets a map request still inside the block run out, with margin.
  localparam int SETTLE_CYCLES  = 16;
  // Longest quiet stretch of a correct run is the receiver hold-off below.
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_TARGET    = 1250;
  localparam int NUM_PHASES     = 6;

  logic                clk;
  logic                rst          = 1'b1;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [COUNT_W-1:0]  cfg_data     = '0;
  logic                pixel_valid  = 1'b0;
  logic                pixel_ready;
  pixel_t              pixel        = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  result_t             result;

  int                  mismatches;
  int                  pending;
  int                  results_taken = 0;
  int                  idle_cycles   = 0;
  int                  pixels_sent   = 0;
  bit                  sender_steady = 1'b0;
  bit                  hold_done     = 1'b0;

  per_channel_contrast_stretch dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  pcs_result_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pixel_t make_pixel(input logic func, input logic fs,
                                        input logic [SAMPLE_W-1:0] c0,
                                        input logic [SAMPLE_W-1:0] c1,
                                        input logic [SAMPLE_W-1:0] c2);
    pixel_t p;
    p.func        = func;
    p.frame_start = fs;
    p.chan0       = c0;
    p.chan1       = c1;
    p.chan2       = c2;
    return p;
  endfunction

  function automatic logic [SAMPLE_W-1:0] band_sample(input int lo, input int hi);
    return SAMPLE_W'($urandom_range(hi, lo));
  endfunction

  // Presents one request after an optional gap and holds it until the block takes it.
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) pixel_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // The channel count may only change while the block is idle, so drain it first.
  task automatic set_channel_count(input logic [COUNT_W-1:0] count);
    @(negedge clk) pixel_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // One frame: a measure pass over a chosen band of values, then a map pass.
  // Map samples mostly sit near the band so that the interior gets exercised,
  // and sometimes anywhere so that saturation on both sides shows up.
  task automatic run_frame();
    int lo;
    int hi;
    int n_meas;
    int n_map;
    int map_lo;
    int map_hi;
    logic fs;
    case ($urandom_range(0, 3))
      0: begin
        lo = 0;
        hi = 255;
      end
      1: begin
        lo = $urandom_range(0, 255);
        hi = lo + $urandom_range(0, 12);
        if (hi > 255) hi = 255;
      end
      2: begin
        lo = $urandom_range(0, 255);
        hi = lo;
      end
      default: begin
        lo = $urandom_range(0, 200);
        hi = lo + $urandom_range(20, 55);
      end
    endcase
    n_meas = $urandom_range(1, 8);
    n_map  = $urandom_range(1, 8);
    for (int k = 0; k < n_meas; k++) begin
      // Now and then a frame carries on from the previous statistics.
      fs = (k == 0) && ($urandom_range(0, 9) != 0);
      send_pixel(make_pixel(FUNC_MEASURE, fs, band_sample(lo, hi), band_sample(lo, hi),
                            band_sample(lo, hi)));
    end
    map_lo = (lo > 3) ? lo - 3 : 0;
    map_hi = (hi < 252) ? hi + 3 : 255;
    for (int k = 0; k < n_map; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        map_lo = 0;
        map_hi = 255;
      end
      send_pixel(make_pixel(FUNC_MAP, 1'($urandom_range(0, 1)), band_sample(map_lo, map_hi),
                            band_sample(map_lo, map_hi), band_sample(map_lo, map_hi)));
    end
  endtask

  // Receiver: runs of ready broken by gaps, plus one long hold-off once the
  // stream is going, so that the output register fills and the input stalls.
  initial begin
    int run;
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && results_taken >= 150) begin
        @(negedge clk) result_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      @(negedge clk) result_ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk) result_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // Watchdog: a stretch with no handshake on any channel means the block is stuck.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) results_taken <= results_taken + 1;
    if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [COUNT_W-1:0] phase_counts [NUM_PHASES];
    int                 phase_end;
    phase_counts = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1};

    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed part, starting from the reset count of three channels.
    // A map request before any measurement sees empty ranges everywhere.
    send_pixel(make_pixel(FUNC_MAP,     1'b0, 8'd0,   8'd128, 8'd255));
    // Full range: the ends map to the ends and every other value maps to itself.
    send_pixel(make_pixel(FUNC_MEASURE, 1'b1, 8'd0,   8'd0,   8'd0));
    send_pixel(make_pixel(FUNC_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pixel(FUNC_MAP,     1'b0, 8'd0,   8'd255, 8'd128));
    send_pixel(make_pixel(FUNC_MAP,     1'b0, 8'd1,   8'd254, 8'd127));
    // Channel 1 is flat in this frame; the others have narrow ranges.
    send_pixel(make_pixel(FUNC_MEASURE, 1'b1, 8'd100, 8'd50,  8'd7));
    send_pixel(make_pixel(FUNC_MEASURE, 1'b0, 8'd150, 8'd50,  8'd9));
    // Below the minimum, above the maximum, and a frame start that the map pass ignores.
    send_pixel(make_pixel(FUNC_MAP,     1'b0, 8'd99,  8'd50,  8'd8));
    send_pixel(make_pixel(FUNC_MAP,     1'b1, 8'd151, 8'd200, 8'd9));
    send_pixel(make_pixel(FUNC_MAP,     1'b0, 8'd125, 8'd49,  8'd8));
    // Widen every range without a frame start, then map alternating bit patterns on channels 1 and 2.
    send_pixel(make_pixel(FUNC_MEASURE, 1'b0, 8'd170, 8'd85,  8'd170));
    send_pixel(make_pixel(FUNC_MAP,     1'b0, 8'd135, 8'h55,  8'hAA));

    // One channel: channels 1 and 2 pass through unchanged.
    set_channel_count(2'd1);
    send_pixel(make_pixel(FUNC_MEASURE, 1'b1, 8'd50,  8'd1,   8'd2));
    send_pixel(make_pixel(FUNC_MEASURE, 1'b0, 8'd60,  8'd3,   8'd4));
    send_pixel(make_pixel(FUNC_MAP,     1'b0, 8'd55,  8'd77,  8'd88));

    // A count of zero acts as one; inactive channels keep their statistics.
    set_channel_count(2'd0);
    send_pixel(make_pixel(FUNC_MAP,     1'b0, 8'd60,  8'hFF,  8'h00));
    send_pixel(make_pixel(FUNC_MEASURE, 1'b0, 8'd40,  8'd250, 8'd250));

    // Two channels: channel 1 was never measured since the last frame start.
    set_channel_count(2'd2);
    send_pixel(make_pixel(FUNC_MAP,     1'b0, 8'd45,  8'd2,   8'd200));

    // Random part: well-formed frames with some stray requests mixed in.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_channel_count(phase_counts[ph]);
      sender_steady = (ph == 2);
      phase_end = pixels_sent + (ITEM_TARGET - pixels_sent) / (NUM_PHASES - ph);
      while (pixels_sent < phase_end) begin
        if ($urandom_range(0, 99) < 85) begin
          run_frame();
        end else begin
          send_pixel(make_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                SAMPLE_W'($urandom_range(0, 255)),
                                SAMPLE_W'($urandom_range(0, 255)),
                                SAMPLE_W'($urandom_range(0, 255))));
        end
      end
    end

    @(negedge clk) pixel_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> per_channel_contrast_stretch.f
src/pcs_pkg.sv
src/pcs_ctrl.sv
src/pcs_datapath.sv
src/per_channel_contrast_stretch.sv
tb/pcs_result_checker.sv
tb/tb_per_channel_contrast_stretch.sv
